// ===== rtl/tms_pkg.sv =====
package tms_pkg;

  localparam int POS_W        = 6;
  localparam int SENSE_W      = 3;
  localparam int MOVE_W       = 3;
  localparam int CNT_W        = 2;
  localparam int NUM_DIR      = 4;
  localparam int GRID_DIM_DEF = 64;

  localparam logic [CNT_W-1:0]   CNT_MAX      = 2'd3;
  localparam logic [SENSE_W-1:0] SENSE_FREE   = 3'd0;
  localparam logic [SENSE_W-1:0] SENSE_TARGET = 3'd3;
  localparam logic [MOVE_W-1:0]  MOVE_NONE    = 3'd4;

  typedef enum logic {
    OP_VISIT = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VRD,
    ST_VWR,
    ST_QRD,
    ST_QFIN
  } state_t;

  typedef struct packed {
    logic [NUM_DIR-1:0][SENSE_W-1:0] code;
    logic [NUM_DIR-1:0][CNT_W-1:0]   cnt;
  } pick_in_t;

endpackage

// ===== rtl/tremaux_move_selector.sv =====
// Tremaux move selector: per-cell visit counters (2 bits, saturating at 3)
// in one synchronous memory, plus a move picker.
// Input channel: a word is taken at a clock edge with start high and busy low.
//   in_opcode visit: the counter of cell (in_pos_x, in_pos_y) is incremented;
//   no result. Cells outside the grid are ignored.
//   in_opcode query: the four neighbor counters are read and one move comes
//   back on out_move_dir (0 up, 1 down, 2 left, 3 right, 4 none).
// Result channel: out_valid is high for exactly one cycle per query; the
// receiver cannot stall, so the word must be taken in that cycle.
// Sequencing: the memory has one read port, one write port and registered reads.
//   Query: four neighbor reads in ST_QRD, one per cycle, then the pick in
//   ST_QFIN; out_valid is registered from ST_QFIN. busy is low in ST_QFIN, so
//   the next word can be taken at the edge that ends it.
//   Visit: read in ST_VRD, then write back in ST_VWR; busy is low in ST_VWR,
//   so the next word can be taken at the edge that does the write.
// Reset: a clearing pass writes zero to all min(GRID_WIDTH,64) *
// min(GRID_HEIGHT,64) counters (4096 by default), one entry per cycle; busy is
// high until it ends.
module tremaux_move_selector #(
  parameter int GRID_WIDTH  = tms_pkg::GRID_DIM_DEF,
  parameter int GRID_HEIGHT = tms_pkg::GRID_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [tms_pkg::POS_W-1:0]     in_pos_x,
  input  logic [tms_pkg::POS_W-1:0]     in_pos_y,
  input  logic [tms_pkg::SENSE_W-1:0]   in_sense_up,
  input  logic [tms_pkg::SENSE_W-1:0]   in_sense_down,
  input  logic [tms_pkg::SENSE_W-1:0]   in_sense_left,
  input  logic [tms_pkg::SENSE_W-1:0]   in_sense_right,
  output logic                          out_valid,
  output logic [tms_pkg::MOVE_W-1:0]    out_move_dir
);

  localparam int POS_W   = tms_pkg::POS_W;
  localparam int POS_MAX = 2 ** POS_W;
  localparam int COLS    = (GRID_WIDTH < POS_MAX) ? GRID_WIDTH : POS_MAX;
  localparam int ROWS    = (GRID_HEIGHT < POS_MAX) ? GRID_HEIGHT : POS_MAX;
  localparam int DEPTH   = COLS * ROWS;
  localparam int AW      = $clog2(DEPTH);
  localparam int PROD_W  = 2 * POS_W + 1;
  localparam int CNT_W   = tms_pkg::CNT_W;
  localparam int NUM_DIR = tms_pkg::NUM_DIR;

  // counter store
  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] mem_rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  tms_pkg::state_t  state_r, state_nxt;
  tms_pkg::dir_t    dir_r, dir_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [POS_W-1:0]                              x_r, y_r;
  logic [NUM_DIR-1:0][tms_pkg::SENSE_W-1:0]      sense_r;
  logic [NUM_DIR-1:0][CNT_W-1:0]                 cnt_r;
  tms_pkg::dir_t                                 rd_dir_r;
  logic                                          rd_ok_r, rd_ok_nxt;
  logic [tms_pkg::MOVE_W-1:0]                    out_move_r;

  logic             accept;
  logic [AW:0]      self_cell;
  logic [AW:0]      nb_cell;
  logic [CNT_W-1:0] cap_cnt;
  logic [CNT_W-1:0] sat_cnt;
  logic [tms_pkg::MOVE_W-1:0] pick_move;
  tms_pkg::pick_in_t          pick_in;

  function automatic logic [AW:0] cell_addr(
    input logic [POS_W:0] nx,
    input logic [POS_W:0] ny
  );
    logic [PROD_W-1:0] lin;
    logic              ok;
    lin = PROD_W'(ny[POS_W-1:0]) * PROD_W'(COLS) + PROD_W'(nx[POS_W-1:0]);
    ok  = (nx < (POS_W+1)'(COLS)) && (ny < (POS_W+1)'(ROWS));
    return {ok, lin[AW-1:0]};
  endfunction

  function automatic logic [AW:0] nb_addr(
    input logic [POS_W-1:0] x,
    input logic [POS_W-1:0] y,
    input tms_pkg::dir_t    d
  );
    logic [POS_W:0] nx;
    logic [POS_W:0] ny;
    nx = {1'b0, x};
    ny = {1'b0, y};
    // moving below zero wraps to a value past the grid, so it reads as outside
    unique case (d)
      tms_pkg::DIR_UP:    ny = ny - (POS_W+1)'(1);
      tms_pkg::DIR_DOWN:  ny = ny + (POS_W+1)'(1);
      tms_pkg::DIR_LEFT:  nx = nx - (POS_W+1)'(1);
      tms_pkg::DIR_RIGHT: nx = nx + (POS_W+1)'(1);
    endcase
    return cell_addr(nx, ny);
  endfunction

  assign self_cell = cell_addr({1'b0, x_r}, {1'b0, y_r});
  assign nb_cell   = nb_addr(x_r, y_r, dir_r);
  assign sat_cnt   = (mem_rdata_r == tms_pkg::CNT_MAX) ? tms_pkg::CNT_MAX
                                                       : mem_rdata_r + CNT_W'(1);
  assign cap_cnt   = rd_ok_r ? mem_rdata_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tms_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = tms_pkg::ST_IDLE;
        end
      end
      tms_pkg::ST_IDLE, tms_pkg::ST_VWR, tms_pkg::ST_QFIN: begin
        if (accept) begin
          state_nxt = (in_opcode == tms_pkg::OP_QUERY) ? tms_pkg::ST_QRD
                                                       : tms_pkg::ST_VRD;
        end else begin
          state_nxt = tms_pkg::ST_IDLE;
        end
      end
      tms_pkg::ST_VRD: begin
        state_nxt = tms_pkg::ST_VWR;
      end
      tms_pkg::ST_QRD: begin
        if (dir_r == tms_pkg::DIR_RIGHT) begin
          state_nxt = tms_pkg::ST_QFIN;
        end
      end
      default: state_nxt = tms_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the controller
  always_comb begin
    busy          = 1'b1;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_raddr     = self_cell[AW-1:0];
    clr_nxt       = clr_r;
    dir_nxt       = dir_r;
    cap_nxt       = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      tms_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
      end
      tms_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      tms_pkg::ST_VRD: begin
        mem_raddr = self_cell[AW-1:0];
      end
      tms_pkg::ST_VWR: begin
        busy      = 1'b0;
        mem_we    = self_cell[AW];
        mem_waddr = self_cell[AW-1:0];
        mem_wdata = sat_cnt;
      end
      tms_pkg::ST_QRD: begin
        mem_raddr = nb_cell[AW-1:0];
        cap_nxt   = 1'b1;
        rd_ok_nxt = nb_cell[AW];
        dir_nxt   = tms_pkg::dir_t'(dir_r + 2'd1);
      end
      tms_pkg::ST_QFIN: begin
        busy          = 1'b0;
        out_valid_nxt = 1'b1;
      end
      default: busy = 1'b1;
    endcase
    if (accept) begin
      dir_nxt = tms_pkg::DIR_UP;
    end
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tms_pkg::ST_CLEAR;
      dir_r       <= tms_pkg::DIR_UP;
      clr_r       <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      clr_r       <= clr_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r        <= in_pos_x;
      y_r        <= in_pos_y;
      sense_r[0] <= in_sense_up;
      sense_r[1] <= in_sense_down;
      sense_r[2] <= in_sense_left;
      sense_r[3] <= in_sense_right;
    end
    rd_dir_r <= dir_r;
    rd_ok_r  <= rd_ok_nxt;
    if (cap_r) begin
      cnt_r[rd_dir_r] <= cap_cnt;
    end
    if (state_r == tms_pkg::ST_QFIN) begin
      out_move_r <= pick_move;
    end
  end

  // last neighbor read is forwarded straight into the picker
  always_comb begin
    pick_in.code = sense_r;
    for (int d = 0; d < NUM_DIR; d++) begin
      pick_in.cnt[d] = (cap_r && (rd_dir_r == tms_pkg::dir_t'(d))) ? cap_cnt : cnt_r[d];
    end
  end

  tms_pick u_pick (
    .pick_i   (pick_in),
    .move_dir (pick_move)
  );

  assign out_valid    = out_valid_r;
  assign out_move_dir = out_move_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_strobe_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == tms_pkg::ST_QFIN)
    else $error("result strobe without a finished query");

  a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tms_pkg::ST_QRD) |-> !mem_we)
    else $error("counter write during neighbor reads");

  a_busy_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tms_pkg::ST_CLEAR) |-> busy)
    else $error("word taken during clearing pass");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_move_r <= tms_pkg::MOVE_NONE))
    else $error("move code out of range");

endmodule

// ===== rtl/tms_pick.sv =====
module tms_pick (
  input  tms_pkg::pick_in_t                 pick_i,
  output logic [tms_pkg::MOVE_W-1:0]        move_dir
);

  logic [tms_pkg::NUM_DIR-1:0] tgt;
  logic [tms_pkg::NUM_DIR-1:0] pass;
  logic [tms_pkg::NUM_DIR-1:0] fresh;
  logic [tms_pkg::NUM_DIR-1:0] once;

  function automatic logic [tms_pkg::MOVE_W-1:0] first_of(
    input logic [tms_pkg::NUM_DIR-1:0] v
  );
    logic [tms_pkg::MOVE_W-1:0] m;
    m = tms_pkg::MOVE_NONE;
    for (int d = tms_pkg::NUM_DIR - 1; d >= 0; d--) begin
      if (v[d]) begin
        m = tms_pkg::MOVE_W'(d);
      end
    end
    return m;
  endfunction

  always_comb begin
    for (int d = 0; d < tms_pkg::NUM_DIR; d++) begin
      tgt[d]   = (pick_i.code[d] == tms_pkg::SENSE_TARGET);
      pass[d]  = tgt[d] || (pick_i.code[d] == tms_pkg::SENSE_FREE);
      fresh[d] = pass[d] && (pick_i.cnt[d] == tms_pkg::CNT_W'(0));
      once[d]  = pass[d] && (pick_i.cnt[d] == tms_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    priority if (|tgt) begin
      move_dir = first_of(tgt);
    end else if (|fresh) begin
      move_dir = first_of(fresh);
    end else if (|once) begin
      move_dir = first_of(once);
    end else begin
      move_dir = first_of(pass);
    end
  end

endmodule

// ===== tb/sv/tremaux_move_checker.sv =====
module tremaux_move_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_opcode,
  input  logic [tms_pkg::POS_W-1:0]   in_pos_x,
  input  logic [tms_pkg::POS_W-1:0]   in_pos_y,
  input  logic [tms_pkg::SENSE_W-1:0] in_sense_up,
  input  logic [tms_pkg::SENSE_W-1:0] in_sense_down,
  input  logic [tms_pkg::SENSE_W-1:0] in_sense_left,
  input  logic [tms_pkg::SENSE_W-1:0] in_sense_right,
  input  logic                        out_valid,
  input  logic [tms_pkg::MOVE_W-1:0]  out_move_dir,
  output int                          fail_count,
  output int                          pending
);
  import tms_pkg::*;

  localparam int GRID_W = GRID_DIM_DEF;
  localparam int GRID_H = GRID_DIM_DEF;

  logic [CNT_W-1:0]  cnt_model [GRID_W*GRID_H];
  logic [MOVE_W-1:0] move_q [$];
  int                mismatches;
  logic [MOVE_W-1:0] exp_move;

  // cells off the grid read as never visited
  function automatic logic [CNT_W-1:0] neighbour_count(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return '0;
    return cnt_model[y*GRID_W + x];
  endfunction

  function automatic logic [MOVE_W-1:0] pick_move(int x, int y,
                                                  logic [SENSE_W-1:0] up,
                                                  logic [SENSE_W-1:0] down,
                                                  logic [SENSE_W-1:0] left,
                                                  logic [SENSE_W-1:0] right);
    dir_t               order [NUM_DIR];
    int                 dx [NUM_DIR];
    int                 dy [NUM_DIR];
    logic [SENSE_W-1:0] code [NUM_DIR];
    logic [CNT_W-1:0]   cnt [NUM_DIR];
    logic               open [NUM_DIR];
    order = '{DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT};
    dx    = '{0, 0, -1, 1};
    dy    = '{-1, 1, 0, 0};
    code  = '{up, down, left, right};
    for (int d = 0; d < NUM_DIR; d++) begin
      open[d] = (code[d] == SENSE_FREE) || (code[d] == SENSE_TARGET);
      cnt[d]  = neighbour_count(x + dx[d], y + dy[d]);
    end
    for (int d = 0; d < NUM_DIR; d++)
      if (code[d] == SENSE_TARGET) return {1'b0, order[d]};
    for (int d = 0; d < NUM_DIR; d++)
      if (open[d] && cnt[d] == 2'd0) return {1'b0, order[d]};
    for (int d = 0; d < NUM_DIR; d++)
      if (open[d] && cnt[d] == 2'd1) return {1'b0, order[d]};
    for (int d = 0; d < NUM_DIR; d++)
      if (open[d]) return {1'b0, order[d]};
    return MOVE_NONE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (cnt_model[i]) cnt_model[i] = '0;
      move_q.delete();
    end else begin
      if (out_valid) begin
        if (move_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected move word: move_dir=%0d", out_move_dir);
        end else begin
          exp_move = move_q.pop_front();
          if (out_move_dir !== exp_move) begin
            mismatches++;
            if (mismatches <= 10)
              $display("move_dir mismatch: expected %0d, got %0d", exp_move, out_move_dir);
          end
        end
      end
      if (start && !busy) begin
        if (op_t'(in_opcode) == OP_VISIT) begin
          if (int'(in_pos_x) < GRID_W && int'(in_pos_y) < GRID_H &&
              cnt_model[in_pos_y*GRID_W + in_pos_x] != CNT_MAX)
            cnt_model[in_pos_y*GRID_W + in_pos_x] =
              cnt_model[in_pos_y*GRID_W + in_pos_x] + 1'b1;
        end else begin
          move_q.insert(move_q.size(),
                        pick_move(in_pos_x, in_pos_y, in_sense_up, in_sense_down,
                                  in_sense_left, in_sense_right));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= move_q.size();
  end

endmodule

// ===== tb/sv/tb_tremaux_move_selector.sv =====
module tb_tremaux_move_selector;
  import tms_pkg::*;

  localparam logic [SENSE_W-1:0] SENSE_WALL    = 3'd1;
  localparam logic [SENSE_W-1:0] SENSE_ROBOT   = 3'd2;
  localparam logic [SENSE_W-1:0] SENSE_UNKNOWN = 3'd4;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_opcode;
  logic [POS_W-1:0]    in_pos_x;
  logic [POS_W-1:0]    in_pos_y;
  logic [SENSE_W-1:0]  in_sense_up;
  logic [SENSE_W-1:0]  in_sense_down;
  logic [SENSE_W-1:0]  in_sense_left;
  logic [SENSE_W-1:0]  in_sense_right;
  logic                out_valid;
  logic [MOVE_W-1:0]   out_move_dir;
  int                  fail_count;
  int                  pending;

  int                  max_gap;
  logic [POS_W-1:0]    base_x;
  logic [POS_W-1:0]    base_y;

  tremaux_move_selector i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_sense_up    (in_sense_up),
    .in_sense_down  (in_sense_down),
    .in_sense_left  (in_sense_left),
    .in_sense_right (in_sense_right),
    .out_valid      (out_valid),
    .out_move_dir   (out_move_dir)
  );

  tremaux_move_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_sense_up    (in_sense_up),
    .in_sense_down  (in_sense_down),
    .in_sense_left  (in_sense_left),
    .in_sense_right (in_sense_right),
    .out_valid      (out_valid),
    .out_move_dir   (out_move_dir),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // called at a rising edge; returns at the accepting edge plus the gap
  task automatic send_word(op_t op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [SENSE_W-1:0] up, logic [SENSE_W-1:0] down,
                           logic [SENSE_W-1:0] left, logic [SENSE_W-1:0] right);
    int gap;
    gap = $urandom_range(0, max_gap);
    start          <= 1'b1;
    in_opcode      <= op;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_sense_up    <= up;
    in_sense_down  <= down;
    in_sense_left  <= left;
    in_sense_right <= right;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [SENSE_W-1:0] rand_sense();
    int r;
    r = $urandom_range(0, 11);
    if (r < 5)  return SENSE_FREE;
    if (r < 7)  return SENSE_WALL;
    if (r == 7) return SENSE_TARGET;
    if (r == 8) return SENSE_ROBOT;
    if (r == 9) return SENSE_UNKNOWN;
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic rand_word();
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    op_t              op;
    if ($urandom_range(0, 9) < 7) begin
      x = base_x + 6'($urandom_range(0, 3));
      y = base_y + 6'($urandom_range(0, 3));
    end else begin
      x = 6'($urandom_range(0, 63));
      y = 6'($urandom_range(0, 63));
    end
    op = $urandom_range(0, 1) ? OP_QUERY : OP_VISIT;
    send_word(op, x, y, rand_sense(), rand_sense(), rand_sense(), rand_sense());
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_VISIT;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    in_sense_up    <= SENSE_FREE;
    in_sense_down  <= SENSE_FREE;
    in_sense_left  <= SENSE_FREE;
    in_sense_right <= SENSE_FREE;
    max_gap = 5;
    base_x  = '0;
    base_y  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid corners, walls, odd codes, target priority
    send_word(OP_QUERY, 6'd0, 6'd0, SENSE_FREE, SENSE_FREE, SENSE_FREE, SENSE_FREE);
    send_word(OP_QUERY, 6'd63, 6'd63, SENSE_WALL, SENSE_WALL, SENSE_WALL, SENSE_WALL);
    send_word(OP_QUERY, 6'd10, 6'd10, 3'd5, 3'd6, 3'd7, SENSE_UNKNOWN);
    send_word(OP_QUERY, 6'd10, 6'd10, SENSE_FREE, SENSE_FREE, SENSE_ROBOT, SENSE_TARGET);
    send_word(OP_QUERY, 6'd10, 6'd10, SENSE_WALL, SENSE_TARGET, SENSE_TARGET, SENSE_FREE);
    // counter levels and saturation around (20,20)
    send_word(OP_VISIT, 6'd20, 6'd19, 3'd7, 3'd7, 3'd7, 3'd7);
    send_word(OP_QUERY, 6'd20, 6'd20, SENSE_FREE, SENSE_FREE, SENSE_WALL, SENSE_WALL);
    send_word(OP_VISIT, 6'd20, 6'd21, SENSE_TARGET, SENSE_ROBOT, 3'd5, SENSE_FREE);
    send_word(OP_QUERY, 6'd20, 6'd20, SENSE_FREE, SENSE_FREE, SENSE_WALL, SENSE_WALL);
    repeat (4) send_word(OP_VISIT, 6'd20, 6'd19, SENSE_FREE, SENSE_FREE, SENSE_FREE,
                         SENSE_FREE);
    send_word(OP_QUERY, 6'd20, 6'd20, SENSE_FREE, SENSE_FREE, SENSE_WALL, SENSE_WALL);
    send_word(OP_VISIT, 6'd20, 6'd21, SENSE_FREE, SENSE_FREE, SENSE_FREE, SENSE_FREE);
    send_word(OP_QUERY, 6'd20, 6'd20, SENSE_FREE, SENSE_FREE, SENSE_WALL, SENSE_WALL);
    send_word(OP_QUERY, 6'd20, 6'd20, SENSE_FREE, SENSE_FREE, SENSE_FREE, SENSE_WALL);
    // far edges
    send_word(OP_VISIT, 6'd63, 6'd0, SENSE_FREE, SENSE_FREE, SENSE_FREE, SENSE_FREE);
    send_word(OP_VISIT, 6'd0, 6'd63, SENSE_FREE, SENSE_FREE, SENSE_FREE, SENSE_FREE);
    send_word(OP_QUERY, 6'd62, 6'd0, SENSE_WALL, SENSE_WALL, SENSE_WALL, SENSE_FREE);
    send_word(OP_QUERY, 6'd63, 6'd63, SENSE_ROBOT, SENSE_FREE, SENSE_WALL, SENSE_FREE);
    send_word(OP_QUERY, 6'd0, 6'd62, SENSE_WALL, SENSE_FREE, SENSE_FREE, SENSE_WALL);
    drain();

    // random clusters around a base cell; some blocks run without gaps
    for (int blk = 0; blk < 10; blk++) begin
      base_x  = 6'($urandom_range(0, 63));
      base_y  = 6'($urandom_range(0, 63));
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
      repeat (50) rand_word();
      if (blk == 4) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_tremaux_move_selector passed");
    end else begin
      $display("tb_tremaux_move_selector failed");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb_tremaux_move_selector failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tms_pkg.sv
rtl/tms_pick.sv
rtl/tremaux_move_selector.sv
tb/sv/tremaux_move_checker.sv
tb/sv/tb_tremaux_move_selector.sv
